/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge (reset included).
`define ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rlcs_pkg.sv */
// Types, constants and the gain table of the contrast stretch unit.
package rlcs_pkg;

  localparam int NUM_CH = 3;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_MAP = 1'b1;

  typedef struct packed {
    logic       func;
    logic       frame_start;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  // one queued map word: per channel offset above min and gain
  typedef struct packed {
    logic [NUM_CH-1:0][7:0] diff;
    logic [NUM_CH-1:0][7:0] gain;
  } qent_t;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // floor(255 / d), 0 for d == 0
  function automatic logic [7:0] gain_lut(input logic [7:0] d);
    logic [7:0] g;
    begin
      g = 8'd0;
      if (d >= 8'd128) g = 8'd1;
      else if (d >= 8'd86) g = 8'd2;
      else if (d >= 8'd64) g = 8'd3;
      else if (d >= 8'd52) g = 8'd4;
      else if (d >= 8'd43) g = 8'd5;
      else if (d >= 8'd37) g = 8'd6;
      else if (d >= 8'd32) g = 8'd7;
      else if (d >= 8'd29) g = 8'd8;
      else if (d >= 8'd26) g = 8'd9;
      else if (d >= 8'd24) g = 8'd10;
      else if (d >= 8'd22) g = 8'd11;
      else if (d >= 8'd20) g = 8'd12;
      else if (d >= 8'd19) g = 8'd13;
      else if (d >= 8'd18) g = 8'd14;
      else if (d >= 8'd16) g = 8'd15;
      else begin
        case (d)
          8'd15: g = 8'd17;
          8'd14: g = 8'd18;
          8'd13: g = 8'd19;
          8'd12: g = 8'd21;
          8'd11: g = 8'd23;
          8'd10: g = 8'd25;
          8'd9: g = 8'd28;
          8'd8: g = 8'd31;
          8'd7: g = 8'd36;
          8'd6: g = 8'd42;
          8'd5: g = 8'd51;
          8'd4: g = 8'd63;
          8'd3: g = 8'd85;
          8'd2: g = 8'd127;
          8'd1: g = 8'd255;
          default: g = 8'd0;
        endcase
      end
      return g;
    end
  endfunction

endpackage

/* rtl/rlcs_front.sv */
// Front end: channel min/max statistics and classification of map words.
module rlcs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rlcs_pkg::pix_in_t in_data,
  input  rlcs_pkg::qstat_t  qstat,
  output logic             push,
  output rlcs_pkg::qent_t   push_data
);

  logic [rlcs_pkg::NUM_CH-1:0][7:0] ch_min;
  logic [rlcs_pkg::NUM_CH-1:0][7:0] ch_max;
  logic [rlcs_pkg::NUM_CH-1:0][7:0] px;
  logic accept;

  assign px[0] = in_data.red_in;
  assign px[1] = in_data.green_in;
  assign px[2] = in_data.blue_in;

  assign in_ready = !qstat.full;
  assign accept = in_valid && in_ready;
  assign push = accept && (in_data.func == rlcs_pkg::FUNC_MAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < rlcs_pkg::NUM_CH; c++) begin
        ch_min[c] <= rlcs_pkg::FULL_SCALE;
        ch_max[c] <= 8'd0;
      end
    end else if (accept && (in_data.func == rlcs_pkg::FUNC_MEASURE)) begin
      for (int c = 0; c < rlcs_pkg::NUM_CH; c++) begin
        if (in_data.frame_start) begin
          ch_min[c] <= px[c];
          ch_max[c] <= px[c];
        end else begin
          if (px[c] < ch_min[c]) ch_min[c] <= px[c];
          if (px[c] > ch_max[c]) ch_max[c] <= px[c];
        end
      end
    end
  end

  // gain follows the statistics as they stand; below-min samples map to zero
  always_comb begin
    for (int c = 0; c < rlcs_pkg::NUM_CH; c++) begin
      push_data.gain[c] = (ch_max[c] > ch_min[c]) ?
                          rlcs_pkg::gain_lut(ch_max[c] - ch_min[c]) : 8'd0;
      push_data.diff[c] = (px[c] >= ch_min[c]) ? (px[c] - ch_min[c]) : 8'd0;
    end
  end

endmodule

/* rtl/rlcs_queue.sv */
// Small register queue between the front and back ends.
module rlcs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rlcs_pkg::qent_t push_data,
  input  logic            pop,
  output rlcs_pkg::qent_t pop_data,
  output rlcs_pkg::qstat_t qstat
);

  rlcs_pkg::qent_t entries [rlcs_pkg::QDEPTH];
  logic [rlcs_pkg::QAW-1:0] wr_ptr;
  logic [rlcs_pkg::QAW-1:0] rd_ptr;
  logic [rlcs_pkg::QCW-1:0] count;

  assign qstat.full = (count == rlcs_pkg::QCW'(rlcs_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/rlcs_back.sv */
// Back end: gain multiply, saturation and output register.
module rlcs_back (
  input  logic              clk,
  input  logic              rst,
  input  rlcs_pkg::qstat_t  qstat,
  input  rlcs_pkg::qent_t   pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rlcs_pkg::pix_out_t out_data
);

  logic [rlcs_pkg::NUM_CH-1:0][15:0] prod;
  logic [rlcs_pkg::NUM_CH-1:0][7:0] sat;

  assign pop = !qstat.empty && (!out_valid || out_ready);

  always_comb begin
    for (int c = 0; c < rlcs_pkg::NUM_CH; c++) begin
      prod[c] = 16'(pop_data.diff[c]) * 16'(pop_data.gain[c]);
      sat[c] = (prod[c][15:8] != 8'd0) ? rlcs_pkg::FULL_SCALE : prod[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.red_out <= sat[0];
      out_data.green_out <= sat[1];
      out_data.blue_out <= sat[2];
    end
  end

endmodule

/* rtl/rgb_linear_contrast_stretch_unit.sv */
// Top level of the RGB min/max linear contrast stretch unit.
//
// Each frame is sent twice on the input channel. Measure words (func = 0)
// fold the pixel into per-channel min/max; frame_start restarts them from
// that pixel. Measure words give no output word. Map words (func = 1) give
// one output word each: (value - min) * floor(255 / (max - min)) per channel,
// zero for a flat channel or a value below min, saturated at 255.
// Input and output use valid/ready; a word moves when both are high.
// A map word accepted on the input is written into the queue and is shown on
// out_valid from the output register. Throughput: one word per cycle while
// out_ready stays high; the gain is a table lookup on the current statistics,
// so measure and map words may be mixed freely with no bubbles.
// A four-word queue sits between the statistics front end and the multiply
// back end. When the receiver stalls the queue fills and in_ready drops once
// it is full; no word is lost.
// Reset: min = 255, max = 0 per channel (map output zero until measured),
// queue and output register empty.
module rgb_linear_contrast_stretch_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlcs_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rlcs_pkg::pix_out_t out_data
);

`include "assert_macros.svh"

  rlcs_pkg::qstat_t qstat;
  rlcs_pkg::qent_t  push_data;
  rlcs_pkg::qent_t  pop_data;
  logic push;
  logic pop;

  // statistics and classification
  rlcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples input stalls from output stalls
  rlcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  // multiply, clamp, hold for the receiver
  rlcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_ALWAYS(a_q_state, clk, rst, !(qstat.full && qstat.empty))
  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && qstat.full))
  `ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && qstat.empty))
  `ASSERT_NEXT(a_rst_out, clk, rst, !out_valid)

endmodule
